// ===== hdl/haversine_great_circle_distance_core_defines.svh =====
// ----------------------------------------------------------------------------
// haversine distance core: assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH

// property checked only while out of reset
`define HGCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hgcd assertion failed");

// property checked at every edge, reset included
`define HGCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hgcd assertion failed");

`endif

// ===== hdl/hgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hgcd_pkg
// constants, tables and types shared by the haversine distance core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgcd_pkg;

  // parameter defaults
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int DIST_FRAC_BITS_DEF  = 8;
  localparam int CORDIC_STEPS_DEF    = 24;

  // lane input width: every angle is sign-extended to this
  localparam int LANE_W = 26;
  // width of sin / cos values in q30
  localparam int TRIG_W = 34;
  // quotient bits resolved per divider stage
  localparam int DIV_BITS = 4;
  // steps of the square root (bit weights 2^60 down to 2^0)
  localparam int ISQRT_STEPS = 31;

  localparam logic [23:0] RADIUS_RESET = 24'd1070707;
  localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam int          HALF_TURN_DIV = 720;
  localparam int          TURN_DIV      = 360;

  // arctangent of 2^-i in binary-angle units (2^32 per turn)
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // sin / cos pair leaving a trig lane
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // cycles from an accepted beat to its result strobe
  function automatic int hgcd_latency(input int afb, input int steps);
    int nw;
    int ds;
    nw = LANE_W + (32 - afb) + 1;
    ds = (nw + DIV_BITS - 1) / DIV_BITS;
    return 44 + ds + 2 * steps;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hgcd_sincos.sv =====
// ----------------------------------------------------------------------------
// hgcd_sincos
// degrees to binary angle (pipelined divide by a constant), then a
// pipelined rotation cordic giving sin and cos in q30
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgcd_sincos #(
  parameter int ANGLE_FRAC_BITS = hgcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = hgcd_pkg::CORDIC_STEPS_DEF,
  parameter int DIVISOR         = hgcd_pkg::TURN_DIV
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [hgcd_pkg::LANE_W-1:0] deg_i,
  output logic                                    valid_o,
  output hgcd_pkg::trig_t                         trig_o
);

  localparam int Shift     = 32 - ANGLE_FRAC_BITS;
  localparam int NumW      = hgcd_pkg::LANE_W + Shift + 1;
  localparam int DivStages = (NumW + hgcd_pkg::DIV_BITS - 1) / hgcd_pkg::DIV_BITS;
  localparam int RemW      = $clog2(DIVISOR);
  localparam int TW        = RemW + 1;
  localparam int ZW        = hgcd_pkg::TRIG_W;

  // entry: magnitude scaled and rounding offset added
  logic            ent_vld_q;
  logic            ent_neg_q;
  logic [NumW-1:0] ent_num_q;
  logic [NumW-1:0] ent_num_d;
  logic [hgcd_pkg::LANE_W-1:0] mag;

  always_comb begin
    mag       = deg_i[hgcd_pkg::LANE_W-1] ? $unsigned(-deg_i) : $unsigned(deg_i);
    ent_num_d = (NumW'(mag) << Shift) + NumW'(DIVISOR / 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_neg_q <= deg_i[hgcd_pkg::LANE_W-1];
    ent_num_q <= ent_num_d;
  end

  // restoring divide, a few quotient bits per stage
  logic            dv_vld_q [DivStages];
  logic            dv_neg_q [DivStages];
  logic [RemW-1:0] dv_rem_q [DivStages];
  logic [NumW-1:0] dv_nq_q  [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic            vld_in;
    logic            neg_in;
    logic [RemW-1:0] rem_in;
    logic [NumW-1:0] nq_in;
    logic [RemW-1:0] rem_c;
    logic [NumW-1:0] nq_c;

    if (g == 0) begin : g_first
      assign vld_in = ent_vld_q;
      assign neg_in = ent_neg_q;
      assign rem_in = '0;
      assign nq_in  = ent_num_q;
    end else begin : g_next
      assign vld_in = dv_vld_q[g-1];
      assign neg_in = dv_neg_q[g-1];
      assign rem_in = dv_rem_q[g-1];
      assign nq_in  = dv_nq_q[g-1];
    end

    always_comb begin
      logic [TW-1:0] t;
      rem_c = rem_in;
      nq_c  = nq_in;
      t     = '0;
      for (int b = 0; b < hgcd_pkg::DIV_BITS; b++) begin
        if (g * hgcd_pkg::DIV_BITS + b < NumW) begin
          t    = {rem_c, nq_c[NumW-1]};
          nq_c = {nq_c[NumW-2:0], 1'b0};
          if (t >= TW'(DIVISOR)) begin
            rem_c   = RemW'(t - TW'(DIVISOR));
            nq_c[0] = 1'b1;
          end else begin
            rem_c = t[RemW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g] <= 1'b0;
      end else begin
        dv_vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_neg_q[g] <= neg_in;
      dv_rem_q[g] <= rem_c;
      dv_nq_q[g]  <= nq_c;
    end
  end

  // sign, then fold into the right half plane
  logic          fold_vld_q;
  logic          fold_flip_q;
  logic [ZW-1:0] fold_z_q;
  logic [31:0]   quo;
  logic [31:0]   turn;
  logic [31:0]   shifted;
  logic [31:0]   ang;
  logic          flip;

  always_comb begin
    quo     = dv_nq_q[DivStages-1][31:0];
    turn    = dv_neg_q[DivStages-1] ? (32'd0 - quo) : quo;
    shifted = turn + 32'h4000_0000;
    flip    = shifted[31];
    ang     = flip ? {~turn[31], turn[30:0]} : turn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else begin
      fold_vld_q <= dv_vld_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fold_flip_q <= flip;
    fold_z_q    <= {{(ZW-32){ang[31]}}, ang};
  end

  // rotation cordic, one micro-rotation per stage
  logic                 cr_vld_q  [CORDIC_STEPS];
  logic                 cr_flip_q [CORDIC_STEPS];
  logic signed [ZW-1:0] cr_x_q    [CORDIC_STEPS];
  logic signed [ZW-1:0] cr_y_q    [CORDIC_STEPS];
  logic signed [ZW-1:0] cr_z_q    [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    logic                 vld_in;
    logic                 flip_in;
    logic signed [ZW-1:0] x_in;
    logic signed [ZW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] x_c;
    logic signed [ZW-1:0] y_c;
    logic signed [ZW-1:0] z_c;
    logic signed [ZW-1:0] at;

    if (g == 0) begin : g_first
      assign vld_in  = fold_vld_q;
      assign flip_in = fold_flip_q;
      assign x_in    = ZW'(hgcd_pkg::CORDIC_GAIN);
      assign y_in    = '0;
      assign z_in    = fold_z_q;
    end else begin : g_next
      assign vld_in  = cr_vld_q[g-1];
      assign flip_in = cr_flip_q[g-1];
      assign x_in    = cr_x_q[g-1];
      assign y_in    = cr_y_q[g-1];
      assign z_in    = cr_z_q[g-1];
    end

    assign at = ZW'(hgcd_pkg::ATAN_TAB[g]);

    always_comb begin
      if (!z_in[ZW-1]) begin
        x_c = x_in - (y_in >>> g);
        y_c = y_in + (x_in >>> g);
        z_c = z_in - at;
      end else begin
        x_c = x_in + (y_in >>> g);
        y_c = y_in - (x_in >>> g);
        z_c = z_in + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cr_vld_q[g] <= 1'b0;
      end else begin
        cr_vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      cr_flip_q[g] <= flip_in;
      cr_x_q[g]    <= x_c;
      cr_y_q[g]    <= y_c;
      cr_z_q[g]    <= z_c;
    end
  end

  // undo the fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cr_vld_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr_flip_q[CORDIC_STEPS-1]) begin
      trig_o.sin_v <= -cr_y_q[CORDIC_STEPS-1];
      trig_o.cos_v <= -cr_x_q[CORDIC_STEPS-1];
    end else begin
      trig_o.sin_v <= cr_y_q[CORDIC_STEPS-1];
      trig_o.cos_v <= cr_x_q[CORDIC_STEPS-1];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/haversine_great_circle_distance_core.sv =====
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core
// Great-circle distance between two points given in fixed-point degrees.
// The core is fully pipelined: it takes a new beat in every cycle and
// busy_o stays low. Each result appears on distance_o for exactly one cycle
// with valid_o high. A beat passes through the degree-to-angle divider,
// the rotation cordic of the trig lanes, the 31-step square root and the
// vectoring cordic. The receiver cannot stall, so it must take every
// strobed beat. The radius is read live at the final multiply, so write
// it only while no beat is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module haversine_great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = hgcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int DIST_FRAC_BITS  = hgcd_pkg::DIST_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = hgcd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [23:0] first_latitude_i,
  input  wire logic signed [23:0] second_latitude_i,
  input  wire logic signed [24:0] first_longitude_i,
  input  wire logic signed [24:0] second_longitude_i,
  input  wire logic               sphere_radius_we_i,
  input  wire logic        [23:0] sphere_radius_i,
  output logic                    valid_o,
  output logic             [23:0] distance_o
);

  localparam int LW    = hgcd_pkg::LANE_W;
  localparam int TW    = hgcd_pkg::TRIG_W;
  localparam int Sh    = 38 - DIST_FRAC_BITS;
  localparam int NSq   = hgcd_pkg::ISQRT_STEPS;

  typedef struct packed {
    logic [61:0] v;
    logic [61:0] r;
  } sq_pair_t;

  // magnitude of a q30 value, below 2^31
  function automatic logic [31:0] mag32(input logic signed [TW-1:0] v);
    logic [TW-1:0] n;
    n = v[TW-1] ? $unsigned(-v) : $unsigned(v);
    return n[31:0];
  endfunction

  // round a q60 magnitude to q30 and apply the sign
  function automatic logic signed [TW-1:0] rnd_q30(input logic [63:0] p,
                                                   input logic neg);
    logic [63:0]   s;
    logic [TW-1:0] r;
    s = (p + 64'd536870912) >> 30;
    r = s[TW-1:0];
    return neg ? $signed(-r) : $signed(r);
  endfunction

  // one step of the bitwise square root
  function automatic sq_pair_t sq_step(input sq_pair_t p, input logic [61:0] bw);
    logic [62:0] s;
    sq_pair_t    o;
    s = {1'b0, p.r} + {1'b0, bw};
    if ({1'b0, p.v} >= s) begin
      o.v = p.v - s[61:0];
      o.r = (p.r >> 1) + bw;
    end else begin
      o.v = p.v;
      o.r = p.r >> 1;
    end
    return o;
  endfunction

  // never back-pressures
  assign busy_o = 1'b0;

  // radius register
  logic [23:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= hgcd_pkg::RADIUS_RESET;
    end else if (sphere_radius_we_i) begin
      radius_q <= sphere_radius_i;
    end
  end

  // input stage: differences and sign extension
  logic                 in_vld_q;
  logic signed [LW-1:0] dlat_q;
  logic signed [LW-1:0] dlon_q;
  logic signed [LW-1:0] lat1_q;
  logic signed [LW-1:0] lat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    dlat_q <= LW'(second_latitude_i) - LW'(first_latitude_i);
    dlon_q <= LW'(second_longitude_i) - LW'(first_longitude_i);
    lat1_q <= LW'(first_latitude_i);
    lat2_q <= LW'(second_latitude_i);
  end

  // four trig lanes
  logic            ln_vld [4];
  hgcd_pkg::trig_t ln_trig [4];

  hgcd_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
    .DIVISOR(hgcd_pkg::HALF_TURN_DIV)
  ) u_dlat (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .deg_i(dlat_q),
    .valid_o(ln_vld[0]), .trig_o(ln_trig[0])
  );

  hgcd_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
    .DIVISOR(hgcd_pkg::HALF_TURN_DIV)
  ) u_dlon (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .deg_i(dlon_q),
    .valid_o(ln_vld[1]), .trig_o(ln_trig[1])
  );

  hgcd_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
    .DIVISOR(hgcd_pkg::TURN_DIV)
  ) u_lat1 (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .deg_i(lat1_q),
    .valid_o(ln_vld[2]), .trig_o(ln_trig[2])
  );

  hgcd_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
    .DIVISOR(hgcd_pkg::TURN_DIV)
  ) u_lat2 (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .deg_i(lat2_q),
    .valid_o(ln_vld[3]), .trig_o(ln_trig[3])
  );

  // stage a: raw products
  logic        a_vld_q;
  logic [63:0] a_sd2_q;
  logic [63:0] a_cc_q;
  logic [63:0] a_so2_q;
  logic        a_ccneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= ln_vld[0] & ln_vld[1] & ln_vld[2] & ln_vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    a_sd2_q   <= mag32(ln_trig[0].sin_v) * mag32(ln_trig[0].sin_v);
    a_so2_q   <= mag32(ln_trig[1].sin_v) * mag32(ln_trig[1].sin_v);
    a_cc_q    <= mag32(ln_trig[2].cos_v) * mag32(ln_trig[3].cos_v);
    a_ccneg_q <= ln_trig[2].cos_v[TW-1] ^ ln_trig[3].cos_v[TW-1];
  end

  // stage b: round to q30
  logic                 b_vld_q;
  logic signed [TW-1:0] b_sd2_q;
  logic signed [TW-1:0] b_cc_q;
  logic signed [TW-1:0] b_so2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sd2_q <= rnd_q30(a_sd2_q, 1'b0);
    b_so2_q <= rnd_q30(a_so2_q, 1'b0);
    b_cc_q  <= rnd_q30(a_cc_q, a_ccneg_q);
  end

  // stage c: cos product times squared longitude sine
  logic                 c_vld_q;
  logic [63:0]          c_p_q;
  logic                 c_neg_q;
  logic signed [TW-1:0] c_sd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_p_q   <= mag32(b_cc_q) * mag32(b_so2_q);
    c_neg_q <= b_cc_q[TW-1] ^ b_so2_q[TW-1];
    c_sd2_q <= b_sd2_q;
  end

  // stage d: round
  logic                 d_vld_q;
  logic signed [TW-1:0] d_p_q;
  logic signed [TW-1:0] d_sd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_p_q   <= rnd_q30(c_p_q, c_neg_q);
    d_sd2_q <= c_sd2_q;
  end

  // stage e: haversine term, clamped, and the two root operands
  logic                 e_vld_q;
  sq_pair_t             e_s1_q;
  sq_pair_t             e_s2_q;
  logic signed [TW:0]   hav;
  logic        [30:0]   hav_c;

  always_comb begin
    hav = {d_sd2_q[TW-1], d_sd2_q} + {d_p_q[TW-1], d_p_q};
    if (hav[TW]) begin
      hav_c = '0;
    end else if (hav > (TW+1)'(32'h4000_0000)) begin
      hav_c = 31'h4000_0000;
    end else begin
      hav_c = hav[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_s1_q.v <= {1'b0, hav_c, 30'd0};
    e_s1_q.r <= '0;
    e_s2_q.v <= {1'b0, 31'h4000_0000 - hav_c, 30'd0};
    e_s2_q.r <= '0;
  end

  // two square roots side by side, one bit per stage
  logic     sq_vld_q [NSq];
  sq_pair_t sq_1_q   [NSq];
  sq_pair_t sq_2_q   [NSq];

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    localparam logic [61:0] Bw = 62'd1 << (60 - 2 * k);
    logic     vld_in;
    sq_pair_t p1_in;
    sq_pair_t p2_in;

    if (k == 0) begin : g_first
      assign vld_in = e_vld_q;
      assign p1_in  = e_s1_q;
      assign p2_in  = e_s2_q;
    end else begin : g_next
      assign vld_in = sq_vld_q[k-1];
      assign p1_in  = sq_1_q[k-1];
      assign p2_in  = sq_2_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_1_q[k] <= sq_step(p1_in, Bw);
      sq_2_q[k] <= sq_step(p2_in, Bw);
    end
  end

  // vectoring cordic on (sqrt(1-a), sqrt(a))
  logic                 vc_vld_q [CORDIC_STEPS];
  logic signed [TW-1:0] vc_x_q   [CORDIC_STEPS];
  logic signed [TW-1:0] vc_y_q   [CORDIC_STEPS];
  logic signed [32:0]   vc_z_q   [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    logic                 vld_in;
    logic signed [TW-1:0] x_in;
    logic signed [TW-1:0] y_in;
    logic signed [32:0]   z_in;
    logic signed [TW-1:0] x_c;
    logic signed [TW-1:0] y_c;
    logic signed [32:0]   z_c;
    logic signed [32:0]   at;

    if (g == 0) begin : g_first
      assign vld_in = sq_vld_q[NSq-1];
      assign x_in   = TW'(sq_2_q[NSq-1].r[30:0]);
      assign y_in   = TW'(sq_1_q[NSq-1].r[30:0]);
      assign z_in   = '0;
    end else begin : g_next
      assign vld_in = vc_vld_q[g-1];
      assign x_in   = vc_x_q[g-1];
      assign y_in   = vc_y_q[g-1];
      assign z_in   = vc_z_q[g-1];
    end

    assign at = 33'(hgcd_pkg::ATAN_TAB[g]);

    always_comb begin
      if (!y_in[TW-1] && (y_in != '0)) begin
        x_c = x_in + (y_in >>> g);
        y_c = y_in - (x_in >>> g);
        z_c = z_in + at;
      end else begin
        x_c = x_in - (y_in >>> g);
        y_c = y_in + (x_in >>> g);
        z_c = z_in - at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_vld_q[g] <= 1'b0;
      end else begin
        vc_vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      vc_x_q[g] <= x_c;
      vc_y_q[g] <= y_c;
      vc_z_q[g] <= z_c;
    end
  end

  // stage f: clamp, double, times pi
  logic               f_vld_q;
  logic        [63:0] f_p_q;
  logic signed [32:0] zl;
  logic        [30:0] zc;
  logic        [31:0] cang;

  always_comb begin
    zl = vc_z_q[CORDIC_STEPS-1];
    if (zl[32]) begin
      zc = '0;
    end else if (zl > 33'sh0_4000_0000) begin
      zc = 31'h4000_0000;
    end else begin
      zc = zl[30:0];
    end
    cang = {zc, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= vc_vld_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    f_p_q <= 64'(cang) * 64'(hgcd_pkg::PI_Q30);
  end

  // stage g: central angle in radians, q30
  logic        g_vld_q;
  logic [31:0] g_crad_q;
  logic [63:0] crad_sum;

  assign crad_sum = f_p_q + 64'h4000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_crad_q <= crad_sum[62:31];
  end

  // stage h: radius times angle
  logic        h_vld_q;
  logic [55:0] h_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_p_q <= 56'(radius_q) * 56'(g_crad_q);
  end

  // stage i: round, saturate, strobe out
  logic [56:0] dsum;
  logic [56:0] dsh;
  logic [23:0] dist_c;

  always_comb begin
    dsum = 57'(h_p_q) + (57'd1 << (Sh - 1));
    dsh  = dsum >> Sh;
    if (dsh > 57'hFF_FFFF) begin
      dist_c = 24'hFF_FFFF;
    end else begin
      dist_c = dsh[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    distance_o <= dist_c;
  end

endmodule

`default_nettype wire

// ===== hdl/hgcd_checker.sv =====
// ----------------------------------------------------------------------------
// hgcd_checker
// port-level checks of the haversine distance core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "haversine_great_circle_distance_core_defines.svh"

module hgcd_checker #(
  parameter int ANGLE_FRAC_BITS = hgcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int DIST_FRAC_BITS  = hgcd_pkg::DIST_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = hgcd_pkg::CORDIC_STEPS_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic signed [23:0] first_latitude_i,
  input wire logic signed [23:0] second_latitude_i,
  input wire logic signed [24:0] first_longitude_i,
  input wire logic signed [24:0] second_longitude_i,
  input wire logic               sphere_radius_we_i,
  input wire logic        [23:0] sphere_radius_i,
  input wire logic               valid_o,
  input wire logic        [23:0] distance_o
);

  localparam int Lat = hgcd_pkg::hgcd_latency(ANGLE_FRAC_BITS, CORDIC_STEPS);

  // the pipeline always takes a beat
  `HGCD_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o)

  // every accepted beat gets its strobe a fixed latency later
  `HGCD_ASSERT(a_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##Lat valid_o)

  // no strobe once reset has been seen low
  `HGCD_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |=> !valid_o)

  // a strobe always traces back to an accepted beat
  `HGCD_ASSERT(a_no_phantom, clk_i, rst_ni, valid_o |-> $past(start_i && !busy_o, Lat))

endmodule

bind haversine_great_circle_distance_core hgcd_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
  .DIST_FRAC_BITS(DIST_FRAC_BITS),
  .CORDIC_STEPS(CORDIC_STEPS)
) u_hgcd_checker (.*);

`default_nettype wire
